// ===== design/kbpt_pkg.sv =====
// package with shared constants, types and state codes for the peer table insert block
`default_nettype none
package kbpt_pkg;
  localparam int ID_BITS = 64;
  localparam int SLOTS = 4;
  localparam int MAX_BUCKETS = 16;
  localparam int NUM_SLOTS = MAX_BUCKETS * SLOTS;
  localparam int ADDR_BITS = 32;
  localparam int PORT_BITS = 16;
  localparam int B_W = $clog2(MAX_BUCKETS);
  localparam int S_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SC_W = $clog2(SLOTS + 1);
  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int IDX_W = $clog2(NUM_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SPLIT0,
    ST_SPLIT1,
    ST_RP_RD,
    ST_RP_WR,
    ST_PLACE,
    ST_FAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_inc;
    logic sel_last;
    logic split_half;
    logic split_wr;
    logic rp_rd;
    logic rp_wr;
    logic place;
    logic fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_last;
    logic full;
    logic can_split;
    logic rp_last;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/kbpt_ctrl.sv =====
// controller state machine sequencing search, split, re-placement and placement
`default_nettype none
module kbpt_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_fire,
  output logic           idle,
  input  kbpt_pkg::stat_t st,
  output kbpt_pkg::cmd_t  cmd
);
  kbpt_pkg::state_t state_r, state_nxt;
  logic retried_r, retried_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kbpt_pkg::ST_IDLE;
      retried_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      retried_r <= retried_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    retried_nxt = retried_r;
    cmd         = '0;
    idle        = 1'b0;
    case (state_r)
      kbpt_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          retried_nxt  = 1'b0;
          state_nxt    = kbpt_pkg::ST_SCAN;
        end
      end
      kbpt_pkg::ST_SCAN: begin
        if (st.hit) state_nxt = kbpt_pkg::ST_CHECK;
        else if (st.scan_last) state_nxt = kbpt_pkg::ST_FAIL;
        else cmd.scan_inc = 1'b1;
      end
      kbpt_pkg::ST_CHECK: begin
        if (!st.full) state_nxt = kbpt_pkg::ST_PLACE;
        else if (retried_r) state_nxt = kbpt_pkg::ST_FAIL;
        else state_nxt = kbpt_pkg::ST_SPLIT0;
      end
      kbpt_pkg::ST_SPLIT0: begin
        cmd.sel_last = 1'b1;
        if (st.can_split) begin
          cmd.split_half = 1'b1;
          state_nxt      = kbpt_pkg::ST_SPLIT1;
        end else begin
          state_nxt = kbpt_pkg::ST_FAIL;
        end
      end
      kbpt_pkg::ST_SPLIT1: begin
        cmd.sel_last = 1'b1;
        cmd.split_wr = 1'b1;
        state_nxt    = kbpt_pkg::ST_RP_RD;
      end
      kbpt_pkg::ST_RP_RD: begin
        cmd.rp_rd = 1'b1;
        state_nxt = kbpt_pkg::ST_RP_WR;
      end
      kbpt_pkg::ST_RP_WR: begin
        cmd.rp_wr = 1'b1;
        if (st.rp_last) begin
          cmd.scan_clr = 1'b1;
          retried_nxt  = 1'b1;
          state_nxt    = kbpt_pkg::ST_SCAN;
        end else begin
          state_nxt = kbpt_pkg::ST_RP_RD;
        end
      end
      kbpt_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = kbpt_pkg::ST_DONE;
      end
      kbpt_pkg::ST_FAIL: begin
        cmd.fail  = 1'b1;
        state_nxt = kbpt_pkg::ST_DONE;
      end
      kbpt_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kbpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kbpt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/kbpt_dp.sv =====
// datapath: bucket ranges, slot flags, slot memory and result register
`default_nettype none
module kbpt_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire [kbpt_pkg::ID_BITS-1:0]      in_id,
  input  wire [kbpt_pkg::ADDR_BITS-1:0]    in_addr,
  input  wire [kbpt_pkg::PORT_BITS-1:0]    in_port,
  input  kbpt_pkg::cmd_t                   cmd,
  output kbpt_pkg::stat_t                  st,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_status,
  output logic [kbpt_pkg::B_W-1:0]         out_bucket,
  output logic [kbpt_pkg::S_W-1:0]         out_slot
);
  localparam int IW = kbpt_pkg::ID_BITS;
  localparam int AW = kbpt_pkg::ADDR_BITS;
  localparam int PW = kbpt_pkg::PORT_BITS;
  localparam int BW = kbpt_pkg::B_W;
  localparam int SW = kbpt_pkg::S_W;
  localparam int SCW = kbpt_pkg::SC_W;
  localparam int CW = kbpt_pkg::CNT_W;
  localparam int XW = kbpt_pkg::IDX_W;
  localparam int NS = kbpt_pkg::SLOTS;
  localparam int NB = kbpt_pkg::MAX_BUCKETS;
  localparam int NT = kbpt_pkg::NUM_SLOTS;

  function automatic logic [XW-1:0] sidx(input logic [BW-1:0] b, input logic [SW-1:0] j);
    sidx = XW'(b) * XW'(NS) + XW'(j);
  endfunction

  logic [IW-1:0] id_r;
  logic [AW-1:0] addr_r;
  logic [PW-1:0] port_r;
  logic [IW-1:0] rs_r [NB];
  logic [IW-1:0] re_r [NB];
  logic [CW-1:0] cnt_r;
  logic [NT-1:0] used_r;
  logic [BW-1:0] b_r, last_r;
  logic [IW-1:0] half_r, end_r, mid_r;
  logic [SW-1:0] j_r;
  logic [SCW-1:0] lo_r, hi_r;
  logic [NS-1:0] old_used_r;
  logic [IW-1:0] mem_id [NT];
  logic [AW-1:0] mem_addr [NT];
  logic [PW-1:0] mem_port [NT];
  logic [IW-1:0] rd_id_r;
  logic [AW-1:0] rd_addr_r;
  logic [PW-1:0] rd_port_r;
  logic res_ok_r;
  logic [BW-1:0] res_b_r;
  logic [SW-1:0] res_j_r;
  logic out_valid_r;
  logic out_status_r;
  logic [BW-1:0] out_bucket_r;
  logic [SW-1:0] out_slot_r;

  logic [BW-1:0] rd_idx;
  logic [IW-1:0] rs_q, re_q, mid;
  logic [NS-1:0] bused;
  logic [SW-1:0] free_j;
  logic          any_free;
  logic          go_lo;
  logic          we;
  logic [XW-1:0] wa;
  logic [IW-1:0] wd_id;
  logic [AW-1:0] wd_addr;
  logic [PW-1:0] wd_port;

  function automatic logic [NS-1:0] bused_last();
    bused_last = used_r[sidx(last_r, SW'(0)) +: NS];
  endfunction

  assign rd_idx = cmd.sel_last ? last_r : b_r;
  assign rs_q   = rs_r[rd_idx];
  assign re_q   = re_r[rd_idx];
  assign mid    = rs_q + half_r;
  assign bused  = used_r[sidx(b_r, SW'(0)) +: NS];
  assign go_lo  = (rd_id_r <= mid_r);

  // first free slot of the current bucket
  always_comb begin
    free_j   = '0;
    any_free = 1'b0;
    for (int k = NS - 1; k >= 0; k--) begin
      if (!bused[k]) begin
        free_j   = SW'(k);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    st.hit       = (rs_q <= id_r) && (id_r <= re_q) && (CW'(b_r) < cnt_r);
    st.scan_last = (CW'(b_r) + CW'(1)) >= cnt_r;
    st.full      = !any_free;
    st.can_split = (cnt_r < CW'(NB)) && (rs_q < re_q);
    st.rp_last   = (j_r == SW'(NS - 1));
    st.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    we      = 1'b0;
    wa      = sidx(b_r, free_j);
    wd_id   = id_r;
    wd_addr = addr_r;
    wd_port = port_r;
    if (cmd.place) begin
      we = 1'b1;
    end else if (cmd.rp_wr && old_used_r[j_r]) begin
      we      = 1'b1;
      wa      = go_lo ? sidx(last_r, lo_r[SW-1:0]) : sidx(last_r + BW'(1), hi_r[SW-1:0]);
      wd_id   = rd_id_r;
      wd_addr = rd_addr_r;
      wd_port = rd_port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[wa]   <= wd_id;
      mem_addr[wa] <= wd_addr;
      mem_port[wa] <= wd_port;
    end
    if (cmd.rp_rd) begin
      rd_id_r   <= mem_id[sidx(last_r, j_r)];
      rd_addr_r <= mem_addr[sidx(last_r, j_r)];
      rd_port_r <= mem_port[sidx(last_r, j_r)];
    end
  end

  // payload, split scratch, result and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_id;
      addr_r <= in_addr;
      port_r <= in_port;
    end
    if (cmd.split_half) begin
      half_r <= (re_q - rs_q) >> 1;
      end_r  <= re_q;
    end
    if (cmd.split_wr) begin
      mid_r      <= mid;
      old_used_r <= bused_last();
    end
    if (cmd.place) begin
      res_b_r <= b_r;
      res_j_r <= free_j;
    end
    if (cmd.out_load) begin
      out_status_r <= !res_ok_r;
      out_bucket_r <= res_ok_r ? res_b_r : '0;
      out_slot_r   <= res_ok_r ? res_j_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NB; k++) begin
        rs_r[k] <= '0;
        re_r[k] <= (k == 0) ? '1 : '0;
      end
      cnt_r       <= CW'(1);
      used_r      <= '0;
      b_r         <= '0;
      last_r      <= '0;
      j_r         <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      res_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        b_r    <= '0;
        last_r <= BW'(cnt_r - CW'(1));
      end else if (cmd.scan_inc) begin
        b_r <= b_r + BW'(1);
      end
      if (cmd.split_wr) begin
        re_r[last_r]          <= mid;
        rs_r[last_r + BW'(1)] <= mid + IW'(1);
        re_r[last_r + BW'(1)] <= end_r;
        cnt_r                 <= cnt_r + CW'(1);
        used_r[sidx(last_r, SW'(0)) +: NS] <= '0;
        j_r  <= '0;
        lo_r <= '0;
        hi_r <= '0;
      end
      if (cmd.rp_wr) begin
        j_r <= j_r + SW'(1);
        if (old_used_r[j_r]) begin
          if (go_lo) begin
            used_r[sidx(last_r, lo_r[SW-1:0])] <= 1'b1;
            lo_r <= lo_r + SCW'(1);
          end else begin
            used_r[sidx(last_r + BW'(1), hi_r[SW-1:0])] <= 1'b1;
            hi_r <= hi_r + SCW'(1);
          end
        end
      end
      if (cmd.place) begin
        used_r[sidx(b_r, free_j)] <= 1'b1;
        res_ok_r <= 1'b1;
      end else if (cmd.fail) begin
        res_ok_r <= 1'b0;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;
  assign out_slot   = out_slot_r;
endmodule
`default_nettype wire

// ===== design/kbucket_peer_table_insert_top.sv =====
// top level of the k-bucket peer table insert block
// sequence: a request without a split passes bucket scan, check, place and done; with a split,
// scan and check are followed by split, re-placement and a second scan and check before placement;
// a failure goes through fail and done instead. The bucket scan walks one bucket per cycle;
// re-placement reads each slot of the split bucket and writes it to the lower or upper bucket
// requests: one at a time; the next is taken when the sequencer is back in idle after the result is loaded
// reset: synchronous active-low rst_n; one bucket covering the whole id space, all slots free
`default_nettype none
module kbucket_peer_table_insert_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [111:0] in_tdata,   // peer_id[63:0], peer_address[95:64], peer_port[111:96]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [7:0]   out_tdata   // status[0], bucket_index[4:1], slot_index[6:5], zero[7]
);
  kbpt_pkg::cmd_t  cmd;
  kbpt_pkg::stat_t st;
  logic idle;
  logic in_fire;
  logic                     status;
  logic [kbpt_pkg::B_W-1:0] bucket;
  logic [kbpt_pkg::S_W-1:0] slot;

  // request taken only while the sequencer is idle
  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  kbpt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .idle    (idle),
    .st      (st),
    .cmd     (cmd)
  );

  kbpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_id      (in_tdata[63:0]),
    .in_addr    (in_tdata[95:64]),
    .in_port    (in_tdata[111:96]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_bucket (bucket),
    .out_slot   (slot)
  );

  // result packing, lowest field first
  assign out_tdata = {1'b0, slot, bucket, status};
endmodule
`default_nettype wire
